// File: src/fcb_pkg.sv
// ----------------------------------------------------------------------------
// fcb_pkg : shared types and constants for the CRC-16 frame builder
// Holds the item layout, serialiser status and the byte-wide CRC update.
// ----------------------------------------------------------------------------
package fcb_pkg;

  localparam int unsigned FrameLen = 10;
  localparam int unsigned DataLen  = 8;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  typedef logic [3:0] byte_idx_t;

  // Index of the CRC low byte and of the last byte of a frame
  localparam byte_idx_t CrcLoIdx = byte_idx_t'(DataLen);
  localparam byte_idx_t LastIdx  = byte_idx_t'(FrameLen - 1);

  // Channel a sits in the low bits so the frame shifts out from bit 0
  typedef struct packed {
    logic [15:0] ch_d;
    logic [15:0] ch_c;
    logic [15:0] ch_b;
    logic [15:0] ch_a;
  } item_t;

  // Serialiser status seen by the top level
  typedef struct packed {
    logic      busy;
    logic      advance;
    byte_idx_t idx;
  } ser_stat_t;

  // Fold one byte into a reflected CRC-16 (poly 0xA001)
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: src/four_channel_crc16_frame_builder_top.sv
// ----------------------------------------------------------------------------
// four_channel_crc16_frame_builder_top : four-channel frame builder, CRC-16
// Turns four 16-bit channel values into a ten-byte frame with a MODBUS CRC.
// ----------------------------------------------------------------------------
// Each input transaction carries four channel values and produces ten output
// transactions of one byte each: channels a to d, low byte first, then the
// CRC-16/MODBUS of those eight bytes, low byte first, with out_frame_end high
// on the last byte. The output channel moves one byte per cycle while out_stall
// stays low, and frames follow each other with no gap. A one-entry input
// register takes the next transaction while the current frame is still going
// out; the first byte of a frame is loaded into the output register at the
// same edge that empties that input register, so with the serialiser idle it
// passes through the input register and then the output register. The CRC is
// built one byte per cycle while the output is not stalled, as the data bytes
// pass through the output register.
module four_channel_crc16_frame_builder_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_channel_a,
  input  logic signed [15:0] in_channel_b,
  input  logic signed [15:0] in_channel_c,
  input  logic signed [15:0] in_channel_d,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_frame_byte,
  output logic               out_frame_end
);
  import fcb_pkg::*;

  item_t     in_item;
  item_t     buf_item;
  logic      buf_valid;
  logic      pop;
  ser_stat_t stat;

  // Pack the channels, keeping only the bit pattern
  assign in_item.ch_a = unsigned'(in_channel_a);
  assign in_item.ch_b = unsigned'(in_channel_b);
  assign in_item.ch_c = unsigned'(in_channel_c);
  assign in_item.ch_d = unsigned'(in_channel_d);

  fcb_in_buf u_in_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .pop       (pop),
    .buf_valid (buf_valid),
    .buf_item  (buf_item)
  );

  fcb_serializer u_serializer (
    .clk            (clk),
    .rst_n          (rst_n),
    .src_valid      (buf_valid),
    .src_item       (buf_item),
    .src_pop        (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_frame_byte (out_frame_byte),
    .out_frame_end  (out_frame_end),
    .stat           (stat)
  );

  // Byte index stays inside the frame
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    stat.idx <= LastIdx)
    else $error("frame byte index out of range");

  // Idle serialiser rests at index zero
  a_idle_idx: assert property (@(posedge clk) disable iff (!rst_n)
    !stat.busy |-> stat.idx == '0)
    else $error("idle serialiser with non-zero index");

  // Pop only a held transaction, and only when idle
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> buf_valid && !stat.busy)
    else $error("pop from empty buffer or busy serialiser");

  // Last byte sent ends the frame and marks it
  a_last_byte: assert property (@(posedge clk) disable iff (!rst_n)
    stat.busy && stat.advance && stat.idx == LastIdx |=> !stat.busy && out_valid
      && out_frame_end)
    else $error("frame did not close after its last byte");

endmodule

// File: src/fcb_in_buf.sv
// ----------------------------------------------------------------------------
// fcb_in_buf : one-entry input holding register
// Takes a transaction whenever empty and holds it until the serialiser pops it.
// ----------------------------------------------------------------------------
module fcb_in_buf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  fcb_pkg::item_t in_item,
  input  logic          pop,
  output logic          buf_valid,
  output fcb_pkg::item_t buf_item
);
  import fcb_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  logic  take;

  // Stall only while the entry is occupied
  assign in_stall  = valid_r;
  assign take      = in_valid && !valid_r;
  assign buf_valid = valid_r;
  assign buf_item  = item_r;

  // Fill on accept, drop on pop
  always_comb begin
    valid_nxt = valid_r;
    if (pop) begin
      valid_nxt = 1'b0;
    end else if (take) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold payload
  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_item;
    end
  end

endmodule

// File: src/fcb_serializer.sv
// ----------------------------------------------------------------------------
// fcb_serializer : frame shifter, running CRC and output register
// Emits one frame byte per cycle while out_stall is low, folding data bytes into the CRC.
// ----------------------------------------------------------------------------
module fcb_serializer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                src_valid,
  input  fcb_pkg::item_t      src_item,
  output logic                src_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_frame_byte,
  output logic                out_frame_end,
  output fcb_pkg::ser_stat_t  stat
);
  import fcb_pkg::*;

  logic        busy_r, busy_nxt;
  byte_idx_t   idx_r, idx_nxt;
  logic [63:0] data_r, data_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_end_r, out_end_nxt;
  logic        advance;

  // Output register may load when empty or being taken
  assign advance = !out_valid_r || !out_stall;

  assign out_valid      = out_valid_r;
  assign out_frame_byte = out_byte_r;
  assign out_frame_end  = out_end_r;

  assign stat.busy    = busy_r;
  assign stat.advance = advance;
  assign stat.idx     = idx_r;

  // Pick the next byte and advance the frame
  always_comb begin
    busy_nxt      = busy_r;
    idx_nxt       = idx_r;
    data_nxt      = data_r;
    crc_nxt       = crc_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_end_nxt   = out_end_r;
    src_pop       = 1'b0;
    if (advance) begin
      if (busy_r) begin
        out_valid_nxt = 1'b1;
        out_end_nxt   = 1'b0;
        idx_nxt       = idx_r + byte_idx_t'(1);
        if (idx_r < CrcLoIdx) begin
          // data byte: send and fold into the CRC
          out_byte_nxt = data_r[7:0];
          data_nxt     = {8'h00, data_r[63:8]};
          crc_nxt      = crc16_byte(crc_r, data_r[7:0]);
        end else if (idx_r == CrcLoIdx) begin
          out_byte_nxt = crc_r[7:0];
        end else begin
          // CRC high byte closes the frame
          out_byte_nxt = crc_r[15:8];
          out_end_nxt  = 1'b1;
          busy_nxt     = 1'b0;
          idx_nxt      = '0;
        end
      end else if (src_valid) begin
        // start a new frame, sending its first byte at once
        src_pop       = 1'b1;
        busy_nxt      = 1'b1;
        idx_nxt       = byte_idx_t'(1);
        out_valid_nxt = 1'b1;
        out_end_nxt   = 1'b0;
        out_byte_nxt  = src_item[7:0];
        data_nxt      = {8'h00, src_item[63:8]};
        crc_nxt       = crc16_byte(CrcInit, src_item[7:0]);
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    data_r     <= data_nxt;
    crc_r      <= crc_nxt;
    out_byte_r <= out_byte_nxt;
    out_end_r  <= out_end_nxt;
  end

endmodule
